// ===== sv/plm_pkg.sv =====
// Shared types and constants for the per-node packet loss meter.
`timescale 1ns / 1ps
`default_nettype none
package plm_pkg;

	localparam int KEY_W  = 32;
	localparam int SEQ_W  = 32;
	localparam int TIME_W = 48;
	localparam int CNT_W  = 32;
	localparam int WIN_W  = 32;
	localparam int LOSS_W = 14;
	localparam int SLOT_OUT_W = 4;

	// loss division: numerator lost*10000 + expected/2, divisor expected (33 bits)
	localparam int NUM_W  = 46;
	localparam int DEN_W  = 33;
	localparam int QUOT_W = 14;

	localparam logic [LOSS_W-1:0] LOSS_SCALE   = 14'd10000;
	localparam logic [WIN_W-1:0]  WINDOW_RESET = 32'd10000;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [SEQ_W-1:0]  prev_seq;
		logic [TIME_W-1:0] win_start;
		logic [CNT_W-1:0]  received;
		logic [CNT_W-1:0]  lost;
	} plm_entry_t;

	typedef struct packed {
		logic       used;
		plm_entry_t entry;
	} plm_rd_t;

endpackage
`default_nettype wire

// ===== sv/per_node_packet_loss_meter_core.sv =====
// Per-node packet loss meter: sequencer, window/count update and result register.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------------
//  pkt      | pkt_valid / pkt_stall  | node_key, seq, now_ms
//  res      | res_valid / res_stall  | loss_hundredths, slot_index, evicted,
//           |                        | lost_in_window, received_in_window
//  cfg      | cfg_valid / cfg_ready  | window_length_ms
//
// An item with seq zero goes to the result register without a table search. Otherwise the
// table search reads one slot a cycle through the single table read port and stops at
// the matching slot, or reads every slot on a miss; then the restart, count, multiply
// and add update states and the 14 divider steps follow.
// Reset clears the used flags, so no clearing pass is needed.
// pkt_stall is high while an item is in work; a finished result waits in the output
// register under res_stall while the next item is already taken.
`timescale 1ns / 1ps
`default_nettype none
module per_node_packet_loss_meter_core #(
	parameter int NODE_SLOTS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         pkt_valid,
	output logic        pkt_stall,
	input  wire  [31:0] node_key,
	input  wire  [31:0] seq,
	input  wire  [47:0] now_ms,
	output logic        res_valid,
	input  wire         res_stall,
	output logic [13:0] loss_hundredths,
	output logic [3:0]  slot_index,
	output logic        evicted,
	output logic [31:0] lost_in_window,
	output logic [31:0] received_in_window,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [31:0] window_length_ms
);
	import plm_pkg::*;

	localparam int SLOT_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
	localparam int SCAN_W = SLOT_W + 1;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_RESTART = 3'd2;
	localparam logic [2:0] ST_COUNT   = 3'd3;
	localparam logic [2:0] ST_MUL     = 3'd4;
	localparam logic [2:0] ST_ADD     = 3'd5;
	localparam logic [2:0] ST_DIV     = 3'd6;
	localparam logic [2:0] ST_FIN     = 3'd7;

	logic [2:0]         state_q;
	logic [WIN_W-1:0]   window_q;
	logic [SCAN_W-1:0]  scan_q;
	logic               pend_s1;
	logic [SLOT_W-1:0]  pend_idx_s1;
	logic               free_found_q;
	logic [SLOT_W-1:0]  free_idx_q;
	logic               res_valid_q;

	logic [KEY_W-1:0]   key_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [TIME_W-1:0]  now_q;
	logic               zero_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               evict_q;
	plm_entry_t         entry_q;
	logic [NUM_W-1:0]   prod_s1;
	logic [DEN_W-1:0]   expected_q;

	logic [LOSS_W-1:0]     loss_out_q;
	logic [SLOT_OUT_W-1:0] slot_out_q;
	logic                  evict_out_q;
	logic [CNT_W-1:0]      lost_out_q;
	logic [CNT_W-1:0]      recv_out_q;

	plm_rd_t            rd;
	logic               rd_en;
	logic               accept;
	logic               hit;
	logic               last_pend;
	logic               scan_done;
	logic               cur_free;
	logic               out_free;
	logic               fin_fire;
	logic               restart;
	logic [TIME_W-1:0]  age;
	logic               gap_ok;
	logic [SEQ_W-1:0]   gap;
	logic [CNT_W:0]     lost_sum;
	logic [CNT_W:0]     recv_sum;
	logic               div_start;
	logic               div_done;
	logic [QUOT_W-1:0]  div_quot;
	logic [NUM_W-1:0]   div_num;
	logic [SLOT_W+SLOT_OUT_W-1:0] slot_wide;

	assign accept    = pkt_valid && !pkt_stall;
	assign pkt_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !res_valid_q || !res_stall;
	assign fin_fire  = (state_q == ST_FIN) && out_free;

	assign rd_en     = (state_q == ST_SCAN) && (scan_q < SCAN_W'(NODE_SLOTS));
	assign hit       = pend_s1 && rd.used && (rd.entry.key == key_q);
	assign cur_free  = pend_s1 && !rd.used;
	assign last_pend = (pend_idx_s1 == SLOT_W'(NODE_SLOTS - 1));
	assign scan_done = hit || (pend_s1 && last_pend);

	assign age     = now_q - entry_q.win_start;
	assign restart = (entry_q.win_start == '0) ||
	                 (age >= {{(TIME_W-WIN_W){1'b0}}, window_q}) ||
	                 ((entry_q.prev_seq != '0) && (seq_q <= entry_q.prev_seq));

	assign gap_ok   = (entry_q.prev_seq != '0) &&
	                  ({1'b0, seq_q} > ({1'b0, entry_q.prev_seq} + 33'd1));
	assign gap      = seq_q - entry_q.prev_seq - 32'd1;
	assign lost_sum = {1'b0, entry_q.lost} + {1'b0, gap};
	assign recv_sum = {1'b0, entry_q.received} + 33'd1;

	assign div_start = (state_q == ST_ADD);
	assign div_num   = prod_s1 + NUM_W'(expected_q >> 1);
	assign slot_wide = {{SLOT_OUT_W{1'b0}}, slot_q};

	plm_table #(
		.NODE_SLOTS(NODE_SLOTS),
		.SLOT_W    (SLOT_W)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(scan_q[SLOT_W-1:0]),
		.rd_data(rd),
		.wr_en  (state_q == ST_MUL),
		.wr_addr(slot_q),
		.wr_data(entry_q)
	);

	plm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (expected_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			window_q     <= WINDOW_RESET;
			scan_q       <= '0;
			pend_s1      <= 1'b0;
			free_found_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= window_length_ms;
			end
			res_valid_q <= fin_fire || (res_valid_q && res_stall);
			pend_s1     <= rd_en && !scan_done;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_q       <= '0;
						free_found_q <= 1'b0;
						state_q      <= (seq == '0) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						scan_q <= scan_q + SCAN_W'(1);
					end
					if (cur_free && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_RESTART;
					end
				end
				ST_RESTART: state_q <= ST_COUNT;
				ST_COUNT:   state_q <= ST_MUL;
				ST_MUL:     state_q <= ST_ADD;
				ST_ADD:     state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		pend_idx_s1 <= scan_q[SLOT_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q  <= node_key;
					seq_q  <= seq;
					now_q  <= now_ms;
					zero_q <= (seq == '0);
				end
			end
			ST_SCAN: begin
				if (cur_free && !free_found_q) begin
					free_idx_q <= pend_idx_s1;
				end
				if (hit) begin
					slot_q  <= pend_idx_s1;
					evict_q <= 1'b0;
					entry_q <= rd.entry;
				end else if (pend_s1 && last_pend) begin
					// miss: first free slot, else reuse slot 0
					if (free_found_q) begin
						slot_q <= free_idx_q;
					end else if (cur_free) begin
						slot_q <= pend_idx_s1;
					end else begin
						slot_q <= '0;
					end
					evict_q <= !free_found_q && !cur_free;
					entry_q <= '{key: key_q, prev_seq: '0, win_start: '0,
						received: '0, lost: '0};
				end
			end
			ST_RESTART: begin
				if (restart) begin
					entry_q.win_start <= now_q;
					entry_q.received  <= '0;
					entry_q.lost      <= '0;
				end
			end
			ST_COUNT: begin
				if (gap_ok) begin
					entry_q.lost <= lost_sum[CNT_W] ? '1 : lost_sum[CNT_W-1:0];
				end
				entry_q.received <= recv_sum[CNT_W] ? '1 : recv_sum[CNT_W-1:0];
				entry_q.prev_seq <= seq_q;
			end
			ST_MUL: begin
				prod_s1    <= NUM_W'(entry_q.lost) * NUM_W'(LOSS_SCALE);
				expected_q <= {1'b0, entry_q.received} + {1'b0, entry_q.lost};
			end
			ST_FIN: begin
				if (out_free) begin
					if (zero_q) begin
						loss_out_q  <= '0;
						slot_out_q  <= '0;
						evict_out_q <= 1'b0;
						lost_out_q  <= '0;
						recv_out_q  <= '0;
					end else begin
						loss_out_q  <= div_quot;
						slot_out_q  <= slot_wide[SLOT_OUT_W-1:0];
						evict_out_q <= evict_q;
						lost_out_q  <= entry_q.lost;
						recv_out_q  <= entry_q.received;
					end
				end
			end
			default: ;
		endcase
	end

	assign res_valid          = res_valid_q;
	assign loss_hundredths    = loss_out_q;
	assign slot_index         = slot_out_q;
	assign evicted            = evict_out_q;
	assign lost_in_window     = lost_out_q;
	assign received_in_window = recv_out_q;

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its state");

	a_loss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (loss_hundredths <= 14'd10000))
		else $error("loss above 100 percent");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && received_in_window == '0) |->
			(lost_in_window == '0 && loss_hundredths == '0 && evicted == 1'b0))
		else $error("empty result carries counts");

	a_no_loss_no_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && lost_in_window == '0) |-> (loss_hundredths == '0))
		else $error("nonzero ratio without lost items");

	a_stall_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !out_free) |=> (pkt_stall && res_valid))
		else $error("result dropped while output held");

endmodule
`default_nettype wire

// ===== sv/plm_table.sv =====
// Node table: entry memory with registered read, and per-slot used flags.
`timescale 1ns / 1ps
`default_nettype none
module plm_table #(
	parameter int NODE_SLOTS = 16,
	parameter int SLOT_W = 4
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     rd_en,
	input  wire [SLOT_W-1:0]        rd_addr,
	output plm_pkg::plm_rd_t        rd_data,
	input  wire                     wr_en,
	input  wire [SLOT_W-1:0]        wr_addr,
	input  wire plm_pkg::plm_entry_t wr_data
);
	import plm_pkg::*;

	plm_entry_t              mem [NODE_SLOTS];
	logic [NODE_SLOTS-1:0]   used_q;
	plm_entry_t              rd_entry_q;
	logic                    rd_used_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			rd_used_q <= 1'b0;
		end else begin
			if (wr_en) begin
				used_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_used_q <= used_q[rd_addr];
			end
		end
	end

	assign rd_data.used  = rd_used_q;
	assign rd_data.entry = rd_entry_q;

endmodule
`default_nettype wire

// ===== sv/plm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the loss ratio.
`timescale 1ns / 1ps
`default_nettype none
module plm_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [plm_pkg::NUM_W-1:0]     num,
	input  wire [plm_pkg::DEN_W-1:0]     den,
	output logic                         done,
	output logic [plm_pkg::QUOT_W-1:0]   quot
);
	import plm_pkg::*;

	localparam int STEP_W = $clog2(QUOT_W);

	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  den_sh_q;
	logic [QUOT_W-1:0] quot_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic              take;

	// quotient is known to fit QUOT_W bits (lost <= expected)
	assign take = (rem_q >= den_sh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(QUOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= num;
			den_sh_q <= {den, {(QUOT_W-1){1'b0}}};
			quot_q   <= '0;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= rem_q - den_sh_q;
			end
			quot_q   <= {quot_q[QUOT_W-2:0], take};
			den_sh_q <= den_sh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

// ===== tb/sv/per_node_packet_loss_meter_core_test.sv =====
// Self-checking testbench for the per-node packet loss meter core.
`timescale 1ns / 1ps
module per_node_packet_loss_meter_core_test;
	import plm_pkg::*;

	localparam int NODE_SLOTS = 16;
	localparam int DRAIN_CYCLES = 48;

	typedef struct packed {
		logic [LOSS_W-1:0]     loss;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  evicted;
		logic [CNT_W-1:0]      lost;
		logic [CNT_W-1:0]      received;
	} loss_result_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              pkt_valid = 1'b0;
	logic              pkt_stall;
	logic [KEY_W-1:0]  node_key = '0;
	logic [SEQ_W-1:0]  seq = '0;
	logic [TIME_W-1:0] now_ms = '0;

	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic [LOSS_W-1:0]     loss_hundredths;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic                  evicted;
	logic [CNT_W-1:0]      lost_in_window;
	logic [CNT_W-1:0]      received_in_window;

	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [WIN_W-1:0] window_length_ms = WINDOW_RESET;

	per_node_packet_loss_meter_core i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.pkt_valid          (pkt_valid),
		.pkt_stall          (pkt_stall),
		.node_key           (node_key),
		.seq                (seq),
		.now_ms             (now_ms),
		.res_valid          (res_valid),
		.res_stall          (res_stall),
		.loss_hundredths    (loss_hundredths),
		.slot_index         (slot_index),
		.evicted            (evicted),
		.lost_in_window     (lost_in_window),
		.received_in_window (received_in_window),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.window_length_ms   (window_length_ms)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// node table as the block should hold it
	logic [WIN_W-1:0]  cur_window = WINDOW_RESET;
	logic              tab_used     [NODE_SLOTS];
	logic [KEY_W-1:0]  tab_key      [NODE_SLOTS];
	logic [SEQ_W-1:0]  tab_prev_seq [NODE_SLOTS];
	logic [TIME_W-1:0] tab_start    [NODE_SLOTS];
	logic [CNT_W-1:0]  tab_received [NODE_SLOTS];
	logic [CNT_W-1:0]  tab_lost     [NODE_SLOTS];

	loss_result_t loss_q [$];
	int mismatch_count = 0;

	int  burst_left = 0;
	bit  steady_send = 1'b0;
	bit  hold_armed = 1'b0;
	int  hold_left = 0;
	int  mode_left = 0;
	logic [3:0] stall_phase = '0;
	stall_mode_t stall_mode = STALL_NONE;

	initial begin
		for (int i = 0; i < NODE_SLOTS; i++) begin
			tab_used[i] = 1'b0;
			tab_key[i] = '0;
			tab_prev_seq[i] = '0;
			tab_start[i] = '0;
			tab_received[i] = '0;
			tab_lost[i] = '0;
		end
	end

	function automatic loss_result_t meter_packet(input logic [KEY_W-1:0] key,
		input logic [SEQ_W-1:0] sq, input logic [TIME_W-1:0] t);
		loss_result_t r;
		int hit;
		int free_idx;
		logic [TIME_W-1:0] age;
		logic [63:0] sum;
		logic [63:0] total;
		r = '0;
		if (sq == '0)
			return r;
		hit = -1;
		free_idx = -1;
		for (int i = 0; i < NODE_SLOTS; i++) begin
			if (hit < 0 && tab_used[i] && tab_key[i] == key)
				hit = i;
			if (hit < 0 && !tab_used[i] && free_idx < 0)
				free_idx = i;
		end
		if (hit < 0) begin
			if (free_idx < 0) begin
				free_idx = 0;
				r.evicted = 1'b1;
			end
			hit = free_idx;
			tab_used[hit] = 1'b1;
			tab_key[hit] = key;
			tab_prev_seq[hit] = '0;
			tab_start[hit] = '0;
			tab_received[hit] = '0;
			tab_lost[hit] = '0;
		end
		age = t - tab_start[hit];
		if (tab_start[hit] == '0 || age >= {16'd0, cur_window} ||
			(tab_prev_seq[hit] != '0 && sq <= tab_prev_seq[hit])) begin
			tab_start[hit] = t;
			tab_received[hit] = '0;
			tab_lost[hit] = '0;
		end
		// previous seq at max never yields a gap: 33-bit compare
		if (tab_prev_seq[hit] != '0 && {1'b0, sq} > {1'b0, tab_prev_seq[hit]} + 33'd1) begin
			sum = 64'(tab_lost[hit]) + 64'(sq) - 64'(tab_prev_seq[hit]) - 64'd1;
			tab_lost[hit] = (sum > 64'hFFFF_FFFF) ? '1 : sum[CNT_W-1:0];
		end
		if (tab_received[hit] != '1)
			tab_received[hit] = tab_received[hit] + 1'b1;
		tab_prev_seq[hit] = sq;
		total = 64'(tab_received[hit]) + 64'(tab_lost[hit]);
		r.loss = LOSS_W'((64'(tab_lost[hit]) * 64'd10000 + total / 2) / total);
		r.slot = hit[SLOT_OUT_W-1:0];
		r.lost = tab_lost[hit];
		r.received = tab_received[hit];
		return r;
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		loss_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				cur_window = window_length_ms;
			if (res_valid && !res_stall) begin
				if (loss_q.size() == 0) begin
					$error("result item with no packet pending");
					mismatch_count++;
				end else begin
					want = loss_q.pop_front();
					check_field("loss_hundredths", want.loss, loss_hundredths);
					check_field("slot_index", want.slot, slot_index);
					check_field("evicted", want.evicted, evicted);
					check_field("lost_in_window", want.lost, lost_in_window);
					check_field("received_in_window", want.received, received_in_window);
				end
			end
			if (pkt_valid && !pkt_stall)
				loss_q.push_back(meter_packet(node_key, seq, now_ms));
		end
	end

	// result side: changing stall modes, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_armed) begin
			hold_armed = 1'b0;
			hold_left = 400;
		end
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		stall_phase <= stall_phase + 1'b1;
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE: res_stall <= 1'b0;
				STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 6);
				default: res_stall <= (stall_phase[2:1] == 2'b11);
			endcase
		end
	end

	task automatic send_packet(input logic [KEY_W-1:0] key, input logic [SEQ_W-1:0] sq,
		input logic [TIME_W-1:0] t);
		int gap;
		if (burst_left == 0 && !steady_send) begin
			gap = $urandom_range(0, 5);
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
			if (gap != 0) begin
				pkt_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		pkt_valid <= 1'b1;
		node_key <= key;
		seq <= sq;
		now_ms <= t;
		do @(posedge clk); while (pkt_stall);
	endtask

	task automatic wait_drained();
		pkt_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (loss_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		window_length_ms <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_zero_and_extremes();
		send_packet(32'hFFFF_FFFF, 32'd0, 48'hFFFF_FFFF_FFFF);
		// window started at time zero counts as unset
		send_packet(32'h0, 32'd1, 48'd0);
		send_packet(32'h0, 32'd3, 48'd0);
		// top of the sequence space, then a drop back
		send_packet(32'h1234_5678, 32'hFFFF_FFFE, 48'd1000);
		send_packet(32'h1234_5678, 32'hFFFF_FFFF, 48'd1001);
		send_packet(32'h1234_5678, 32'd1, 48'd1002);
		// huge gap, time wraps but stays inside the window
		send_packet(32'h89AB_CDEF, 32'd1, 48'hFFFF_FFFF_FFFF);
		send_packet(32'h89AB_CDEF, 32'hFFFF_FFFF, 48'd5);
		// time going backwards expires the window
		send_packet(32'h0F0F_0F0F, 32'd100, 48'd500000);
		send_packet(32'h0F0F_0F0F, 32'd105, 48'd499000);
		send_packet(32'h0F0F_0F0F, 32'd0, 48'd499500);
		// age equal to the window restarts, one less does not
		send_packet(32'h0F0F_0F0F, 32'd106, 48'd509000);
		send_packet(32'h0F0F_0F0F, 32'd107, 48'd518999);
	endtask

	task automatic test_window_edges();
		write_window(32'd1);
		send_packet(32'h5555_AAAA, 32'd1, 48'd10);
		send_packet(32'h5555_AAAA, 32'd2, 48'd10);
		send_packet(32'h5555_AAAA, 32'd3, 48'd11);
		write_window(32'hFFFF_FFFF);
		send_packet(32'h5555_AAAA, 32'd4, 48'd12);
		send_packet(32'h5555_AAAA, 32'd5, 48'd11 + 48'hFFFF_FFFE);
		send_packet(32'h5555_AAAA, 32'd6, 48'd11 + 48'hFFFF_FFFF);
	endtask

	task automatic test_table_eviction();
		// more fresh nodes than slots: slot 0 gets reused
		for (int i = 0; i < NODE_SLOTS + 1; i++)
			send_packet(32'hC0DE_0000 + i, i + 1, 48'd2000 + i);
		send_packet(32'hC0DE_0000, 32'd40, 48'd2100);
	endtask

	task automatic test_output_backpressure();
		wait_drained();
		hold_armed = 1'b1;
		steady_send = 1'b1;
		for (int i = 0; i < 40; i++)
			send_packet(32'hBEEF_0000 + (i % 5), i + 1, 48'd3000 + i);
		steady_send = 1'b0;
	endtask

	task automatic test_random_traffic(input int count, input int pool_n);
		logic [KEY_W-1:0] pool_key [20];
		logic [SEQ_W-1:0] pool_seq [20];
		logic [TIME_W-1:0] t;
		logic [31:0] step_cap;
		logic [32:0] nxt;
		int p;
		int r;
		for (int i = 0; i < 20; i++) begin
			pool_key[i] = $urandom;
			pool_seq[i] = ($urandom_range(0, 7) == 0) ?
				32'hFFFF_FFF0 + $urandom_range(0, 14) : $urandom_range(1, 5000);
		end
		t = 48'({$urandom, $urandom});
		// keep per-node packet spacing well inside the window
		step_cap = cur_window / (pool_n * 6);
		if (step_cap == 0)
			step_cap = 1;
		repeat (count) begin
			r = $urandom_range(0, 99);
			p = $urandom_range(0, pool_n - 1);
			t = t + 48'($urandom_range(0, step_cap));
			if (r < 5) begin
				send_packet($urandom, 32'd0, 48'({$urandom, $urandom}));
			end else if (r < 10) begin
				send_packet($urandom, $urandom, 48'({$urandom, $urandom}));
			end else if (r < 13) begin
				t = t - 48'($urandom_range(1, step_cap + 1));
				send_packet(pool_key[p], pool_seq[p], t);
			end else if (r < 17) begin
				pool_seq[p] = pool_seq[p] - $urandom_range(0, 3);
				if (pool_seq[p] == '0)
					pool_seq[p] = 32'd1;
				send_packet(pool_key[p], pool_seq[p], t);
			end else begin
				nxt = 33'(pool_seq[p]) + 33'd1 +
					(($urandom_range(0, 7) == 0) ? 33'($urandom_range(1, 20)) : 33'd0);
				if (nxt > 33'hFFFF_FFFF)
					nxt = 33'd1;
				pool_seq[p] = nxt[SEQ_W-1:0];
				send_packet(pool_key[p], pool_seq[p], t);
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_and_extremes();
		test_window_edges();
		test_table_eviction();
		test_output_backpressure();
		write_window(WINDOW_RESET);
		test_random_traffic(170, 12);
		write_window(32'd60);
		test_random_traffic(170, 20);
		write_window(32'd1);
		test_random_traffic(120, 8);
		write_window(32'hFFFF_FFFF);
		test_random_traffic(170, 14);
		write_window($urandom_range(200, 200000));
		test_random_traffic(170, 18);
		wait_drained();
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
